FILE: rtl/twsa_pkg.sv
// Package for the time-weighted sample average block.
// Holds widths, constants and the sequencer state type; depends on nothing.
`timescale 1ns / 1ps
package twsa_pkg;
   localparam int DEPTH_DEFAULT = 8;
   localparam int LEVEL_W = 10;
   localparam int TIME_W = 32;
   localparam int AGE_W = 16;
   localparam int QUOT_W = 10;
   localparam int WEIGHT_W = 2 * QUOT_W;
   localparam int PROD_W = WEIGHT_W + LEVEL_W;
   localparam logic [15:0] MAX_AGE_RESET = 16'd2000;
   // The weight step of 100 ms is applied as a multiply by ceil(2^24 / 100) and a shift by 24.
   localparam int RECIP_W = 18;
   localparam logic [RECIP_W-1:0] RECIP_STEP = 18'd167773;
   localparam int RECIP_SHIFT = 24;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 16;
   localparam logic CMD_STORE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_AGE,
      S_QUOT,
      S_WGT,
      S_ACC,
      S_DIV,
      S_DONE
   } state_type;
endpackage

FILE: rtl/time_weighted_sample_average.sv
// Top level of the time-weighted sample average block.
// Uses twsa_pkg for widths, constants and the sequencer state type.
// A store beat is handled in the idle state. While a query is worked on, no new request is taken:
// the history rotates past one shared multiply chain in four steps per entry, and a restoring
// divider then produces one bit of the ten-bit level per cycle.
`timescale 1ns / 1ps
module time_weighted_sample_average
   import twsa_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [15:0]           csr_wdata,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // Fields from bit 0: sample [9:0], time_ms [41:10], zero fill.
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // Fields from bit 0: command.
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // Fields from bit 0: level [9:0], zero fill.
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // Fields from bit 0: fallback.
   output logic                  rsp_tuser
);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int WSUM_W = WEIGHT_W + CNT_W;
   localparam int SUM_W = PROD_W + CNT_W;
   localparam int BIT_W = $clog2(QUOT_W);
   localparam int MUL_W = AGE_W + RECIP_W;

   state_type state_ff, state_in;
   logic [15:0] max_age_ff;
   logic [LEVEL_W-1:0] smp_ff [DEPTH];
   logic [LEVEL_W-1:0] smp_in [DEPTH];
   logic [TIME_W-1:0] tim_ff [DEPTH];
   logic [TIME_W-1:0] tim_in [DEPTH];
   logic [TIME_W-1:0] now_ff, now_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [BIT_W-1:0] bit_ff, bit_in;
   logic keep_ff, keep_in;
   logic live_ff, live_in;
   logic [AGE_W-1:0] diff_ff, diff_in;
   logic [QUOT_W-1:0] q_ff, q_in;
   logic [WEIGHT_W-1:0] w_ff, w_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [WSUM_W-1:0] wsum_ff, wsum_in;
   logic [SUM_W-1:0] div_ff, div_in;
   logic [LEVEL_W-1:0] lvl_ff, lvl_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [LEVEL_W-1:0] rsp_level_ff, rsp_level_in;
   logic rsp_fb_ff, rsp_fb_in;
   logic [TIME_W-1:0] age;
   logic [MUL_W-1:0] recip_prod;
   logic [WEIGHT_W-1:0] w_prod;
   logic [PROD_W-1:0] acc_prod;
   logic out_free;
   logic req_take;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign req_take = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE) && out_free;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {{(RSP_DATA_W - LEVEL_W){1'b0}}, rsp_level_ff};
   assign rsp_tuser = rsp_fb_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         max_age_ff <= MAX_AGE_RESET;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < DEPTH; i++) begin
            smp_ff[i] <= '0;
            tim_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            max_age_ff <= csr_wdata;
         end
         for (int i = 0; i < DEPTH; i++) begin
            smp_ff[i] <= smp_in[i];
            tim_ff[i] <= tim_in[i];
         end
      end
      now_ff <= now_in;
      cnt_ff <= cnt_in;
      bit_ff <= bit_in;
      keep_ff <= keep_in;
      live_ff <= live_in;
      diff_ff <= diff_in;
      q_ff <= q_in;
      w_ff <= w_in;
      sum_ff <= sum_in;
      wsum_ff <= wsum_in;
      div_ff <= div_in;
      lvl_ff <= lvl_in;
      rsp_level_ff <= rsp_level_in;
      rsp_fb_ff <= rsp_fb_in;
   end

   always_comb begin
      state_in = state_ff;
      smp_in = smp_ff;
      tim_in = tim_ff;
      now_in = now_ff;
      cnt_in = cnt_ff;
      bit_in = bit_ff;
      keep_in = keep_ff;
      live_in = live_ff;
      diff_in = diff_ff;
      q_in = q_ff;
      w_in = w_ff;
      sum_in = sum_ff;
      wsum_in = wsum_ff;
      div_in = div_ff;
      lvl_in = lvl_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_level_in = rsp_level_ff;
      rsp_fb_in = rsp_fb_ff;
      age = now_ff - tim_ff[DEPTH-1];
      recip_prod = {{(MUL_W - AGE_W){1'b0}}, diff_ff} * {{(MUL_W - RECIP_W){1'b0}}, RECIP_STEP};
      w_prod = {{QUOT_W{1'b0}}, q_ff} * {{QUOT_W{1'b0}}, q_ff};
      acc_prod = {{LEVEL_W{1'b0}}, w_ff} * {{WEIGHT_W{1'b0}}, smp_ff[DEPTH-1]};
      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               if (req_tuser == CMD_STORE) begin
                  for (int i = 0; i < DEPTH - 1; i++) begin
                     smp_in[i] = smp_ff[i+1];
                     tim_in[i] = tim_ff[i+1];
                  end
                  smp_in[DEPTH-1] = req_tdata[LEVEL_W-1:0];
                  tim_in[DEPTH-1] = req_tdata[LEVEL_W +: TIME_W];
                  rsp_valid_in = 1'b1;
                  rsp_level_in = req_tdata[LEVEL_W-1:0];
                  rsp_fb_in = 1'b0;
               end else begin
                  now_in = req_tdata[LEVEL_W +: TIME_W];
                  cnt_in = '0;
                  live_in = 1'b1;
                  sum_in = '0;
                  wsum_in = '0;
                  state_in = S_AGE;
               end
            end
         end
         S_AGE: begin
            keep_in = live_ff && (age <= {{(TIME_W - AGE_W){1'b0}}, max_age_ff});
            diff_in = max_age_ff - age[AGE_W-1:0];
            state_in = S_QUOT;
         end
         S_QUOT: begin
            q_in = recip_prod[RECIP_SHIFT +: QUOT_W];
            state_in = S_WGT;
         end
         S_WGT: begin
            w_in = w_prod;
            state_in = S_ACC;
         end
         S_ACC: begin
            if (keep_ff) begin
               sum_in = sum_ff + {{(SUM_W - PROD_W){1'b0}}, acc_prod};
               wsum_in = wsum_ff + {{(WSUM_W - WEIGHT_W){1'b0}}, w_ff};
            end else begin
               live_in = 1'b0;
            end
            smp_in[0] = smp_ff[DEPTH-1];
            tim_in[0] = tim_ff[DEPTH-1];
            for (int i = 1; i < DEPTH; i++) begin
               smp_in[i] = smp_ff[i-1];
               tim_in[i] = tim_ff[i-1];
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DEPTH - 1)) begin
               div_in = {{(SUM_W - WSUM_W - QUOT_W + 1){1'b0}}, wsum_in,
                         {(QUOT_W - 1){1'b0}}};
               bit_in = '0;
               state_in = S_DIV;
            end else begin
               state_in = S_AGE;
            end
         end
         S_DIV: begin
            if (sum_ff >= div_ff) begin
               sum_in = sum_ff - div_ff;
               lvl_in = {lvl_ff[LEVEL_W-2:0], 1'b1};
            end else begin
               lvl_in = {lvl_ff[LEVEL_W-2:0], 1'b0};
            end
            div_in = div_ff >> 1;
            bit_in = bit_ff + 1'b1;
            if (bit_ff == BIT_W'(QUOT_W - 1)) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (wsum_ff == '0) begin
                  rsp_level_in = smp_ff[DEPTH-1];
                  rsp_fb_in = 1'b1;
               end else begin
                  rsp_level_in = lvl_ff;
                  rsp_fb_in = 1'b0;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end
endmodule

FILE: tb/tb.sv
// Testbench for the time-weighted sample average block.
// A scoreboard class predicts every response beat from its own copy of the history; depends on
// twsa_pkg and time_weighted_sample_average.
`timescale 1ns / 1ps
module tb;
   import twsa_pkg::*;

   localparam int DEPTH = DEPTH_DEFAULT;

   typedef struct packed {
      logic [LEVEL_W-1:0] level;
      logic               fallback;
   } level_result_type;

   class level_scoreboard;
      logic [LEVEL_W-1:0] samples[DEPTH];
      logic [TIME_W-1:0]  stamps[DEPTH];
      logic [15:0]        max_age;
      level_result_type   pending[$];
      int                 errors;
      int                 checked;

      function void clear();
         for (int i = 0; i < DEPTH; i++) begin
            samples[i] = '0;
            stamps[i] = '0;
         end
         max_age = MAX_AGE_RESET;
         errors = 0;
         checked = 0;
      endfunction

      function void note_request(logic cmd, logic [LEVEL_W-1:0] smp, logic [TIME_W-1:0] now);
         level_result_type r;
         logic [TIME_W-1:0] age;
         logic [63:0] w, acc, wacc;
         acc = 0;
         wacc = 0;
         r.fallback = 1'b0;
         if (cmd == CMD_STORE) begin
            for (int i = 0; i < DEPTH - 1; i++) begin
               samples[i] = samples[i+1];
               stamps[i] = stamps[i+1];
            end
            samples[DEPTH-1] = smp;
            stamps[DEPTH-1] = now;
            r.level = smp;
         end else if (TIME_W'(now - stamps[DEPTH-1]) > max_age) begin
            r.level = samples[DEPTH-1];
            r.fallback = 1'b1;
         end else begin
            for (int i = DEPTH - 1; i >= 0; i--) begin
               age = now - stamps[i];
               if (age > max_age) break;
               w = 64'((32'(max_age) - age) / 100);
               w = w * w;
               acc += w * 64'(samples[i]);
               wacc += w;
            end
            if (wacc == 0) begin
               r.level = samples[DEPTH-1];
               r.fallback = 1'b1;
            end else begin
               r.level = LEVEL_W'(acc / wacc);
            end
         end
         pending.push_back(r);
      endfunction

      function void check_response(logic [LEVEL_W-1:0] level, logic fallback);
         level_result_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected response level=%0d fallback=%0b", $realtime, level,
                     fallback);
            errors++;
            return;
         end
         e = pending.pop_front();
         checked++;
         if (e.level !== level) begin
            $display("%0t: level mismatch expected %0d actual %0d", $realtime, e.level, level);
            errors++;
         end
         if (e.fallback !== fallback) begin
            $display("%0t: fallback mismatch expected %0b actual %0b", $realtime, e.fallback,
                     fallback);
            errors++;
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [15:0]           csr_wdata;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;

   level_scoreboard board;
   bit   quiet_mode;
   bit   hold_off;
   int   queries;
   int   stores;

   time_weighted_sample_average #(.DEPTH(DEPTH)) uut (
      .clock(clock),
      .reset(reset),
      .csr_we(csr_we),
      .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #4000000;
      $display("Test completed with failures");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         board.check_response(rsp_tdata[LEVEL_W-1:0], rsp_tuser);
      end
   end

   initial begin
      int n;
      rsp_tready = 1'b0;
      @(negedge clock);
      while (1) begin
         if (hold_off) begin
            rsp_tready <= 1'b0;
            repeat (400) @(negedge clock);
            hold_off = 1'b0;
         end else if (!quiet_mode && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            n = $urandom_range(1, 18);
            repeat (n) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
            n = $urandom_range(1, 30);
            repeat (n) @(negedge clock);
         end
      end
   end

   task automatic send_beat(logic cmd, logic [LEVEL_W-1:0] smp, logic [TIME_W-1:0] now);
      int n;
      if (!quiet_mode && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 1'b0;
         n = $urandom_range(1, 18);
         repeat (n) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= {6'b0, now, smp};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_request(cmd, smp, now);
      if (cmd == CMD_QUERY) queries++;
      else stores++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (board.pending.size() != 0) @(negedge clock);
      repeat (60) @(negedge clock);
   endtask

   task automatic write_max_age(logic [15:0] value);
      drain();
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      board.max_age = value;
   endtask

   // A run of stores with small steps mixed with queries close to the stored times.
   task automatic sensor_run(int len, logic [TIME_W-1:0] base);
      logic [TIME_W-1:0] t;
      t = base;
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 2) == 0) begin
            send_beat(CMD_QUERY, LEVEL_W'($urandom), t + $urandom_range(0, 3000));
         end else begin
            t = t + $urandom_range(0, 800);
            send_beat(CMD_STORE, LEVEL_W'($urandom), t);
         end
      end
   endtask

   initial begin
      logic [15:0] ages[6];
      board = new();
      board.clear();
      reset = 1'b1;
      csr_we = 1'b0;
      csr_wdata = '0;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = CMD_STORE;
      quiet_mode = 1'b0;
      hold_off = 1'b0;
      queries = 0;
      stores = 0;
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: empty history, extremes, stale newest, zero weights, wrap of time.
      send_beat(CMD_QUERY, '0, 32'd0);
      send_beat(CMD_QUERY, '1, 32'd2000);
      send_beat(CMD_QUERY, '0, 32'd2001);
      send_beat(CMD_STORE, 10'd1023, 32'hFFFF_FF00);
      send_beat(CMD_STORE, 10'd0, 32'hFFFF_FFFF);
      send_beat(CMD_STORE, 10'd1023, 32'd50);
      send_beat(CMD_QUERY, '0, 32'd60);
      send_beat(CMD_QUERY, '0, 32'd1990);
      send_beat(CMD_QUERY, '0, 32'd3000);
      send_beat(CMD_QUERY, '0, 32'd49);
      write_max_age(16'd0);
      send_beat(CMD_QUERY, '0, 32'd50);
      send_beat(CMD_QUERY, '0, 32'd51);
      write_max_age(16'd99);
      send_beat(CMD_QUERY, '0, 32'd60);
      write_max_age(16'hFFFF);
      send_beat(CMD_STORE, 10'h2AA, 32'hAAAA_AAAA);
      send_beat(CMD_STORE, 10'h155, 32'h5555_5555);
      send_beat(CMD_QUERY, '0, 32'h5555_5555);
      send_beat(CMD_QUERY, '1, 32'h5556_5555);

      // Back-pressure: the receiver stalls while queries keep coming.
      hold_off = 1'b1;
      for (int i = 0; i < 12; i++) send_beat(CMD_QUERY, '0, 32'h5555_6000 + i);
      drain();

      ages = '{16'd100, 16'd2000, 16'd60000, 16'd500, 16'd12345, 16'd65535};
      for (int p = 0; p < 6; p++) begin
         write_max_age(ages[p]);
         for (int k = 0; k < 12; k++) begin
            if ($urandom_range(0, 4) == 0)
               send_beat(1'($urandom_range(0, 1)), LEVEL_W'($urandom), $urandom);
            else
               sensor_run(20, $urandom);
         end
      end

      write_max_age(16'd3000);
      quiet_mode = 1'b1;
      sensor_run(60, 32'hFFFF_F000);
      drain();

      $display("Covered %0d stores and %0d queries, %0d responses checked.", stores, queries,
               board.checked);
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule
